/* rtl/cma_pkg.sv */
// Shared types and constants for the causal moving-average filter.
// Holds the window register layout, queue sizing and the state enums.
// No dependencies; imported by every module of the block.
package cma_pkg;

   // Window length register: fixed width and reset value.
   localparam int CFG_W = 7;
   localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd8;

   // Queue between the front and back parts. The depth is a power of two,
   // so its pointers wrap on their own.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Front part: idle, running-sum update, full re-sum after a window change.
   typedef enum logic [1:0] {
      FE_IDLE,
      FE_UPDATE,
      FE_SWEEP,
      FE_FINISH
   } fe_state_type;

   // Back part: bit-serial divider.
   typedef enum logic [1:0] {
      DV_IDLE,
      DV_RUN,
      DV_DONE
   } dv_state_type;

endpackage

/* rtl/causal_moving_average.sv */
// Causal moving-average filter. With an empty queue and divider, a sample passes the
// front update state, the queue, the divider's idle, run and done states and its output
// register before rsp_valid rises; the first sample after a window change, unless it
// starts a new series, first re-sums the window from the ring. The bit-serial divider
// takes no new pair before the last is done. Synchronous reset clears the counters, the
// running sum and the queue and loads a window of 8; the sample ring is not cleared.
module causal_moving_average
   import cma_pkg::*;
#(
   parameter int MAX_WINDOW  = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_new_series,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_average,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CFG_W-1:0]              csr_window_length
);

   localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);

   logic                    push_valid;
   logic signed [SUM_W-1:0] push_sum;
   logic [CNT_W-1:0]        push_count;
   logic                    queue_full;
   logic                    pop_valid;
   logic                    pop_ready;
   logic signed [SUM_W-1:0] pop_sum;
   logic [CNT_W-1:0]        pop_count;

   // Front part: ring, running sum and window register.
   cma_front #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS),
      .SUM_W       (SUM_W),
      .CNT_W       (CNT_W)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .req_new_series    (req_new_series),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_window_length (csr_window_length),
      .queue_full        (queue_full),
      .push_valid        (push_valid),
      .push_sum          (push_sum),
      .push_count        (push_count)
   );

   // Queue decoupling the two parts.
   cma_queue #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_sum   (push_sum),
      .push_count (push_count),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_sum    (pop_sum),
      .pop_count  (pop_count)
   );

   // Back part: division and result register.
   cma_divider #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .SUM_W       (SUM_W),
      .CNT_W       (CNT_W)
   ) u_divider (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (pop_valid),
      .in_ready    (pop_ready),
      .in_sum      (pop_sum),
      .in_count    (pop_count),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_average (rsp_average)
   );

endmodule

/* rtl/cma_front.sv */
// Front part of the moving-average filter: sample ring, running sum and
// window register. Pushes (sum, divisor) pairs into the queue.
// Depends on cma_pkg.
module cma_front
   import cma_pkg::*;
#(
   parameter int MAX_WINDOW  = 64,
   parameter int SAMPLE_BITS = 16,
   parameter int SUM_W       = SAMPLE_BITS + $clog2(MAX_WINDOW),
   parameter int CNT_W       = $clog2(MAX_WINDOW + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_new_series,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CFG_W-1:0]              csr_window_length,
   input  logic                          queue_full,
   output logic                          push_valid,
   output logic signed [SUM_W-1:0]       push_sum,
   output logic [CNT_W-1:0]              push_count
);

   localparam int PTR_W = $clog2(MAX_WINDOW);
   localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int AW    = CNT_W + 1;
   localparam int EXT_W = SUM_W - SAMPLE_BITS;

   fe_state_type state_ff, state_in;
   logic [PTR_W-1:0]              wp_ff, wp_in;
   logic [CNT_W-1:0]              held_ff, held_in;
   logic signed [SUM_W-1:0]       sum_ff, sum_in;
   logic                          dirty_ff, dirty_in;
   logic [CFG_W-1:0]              window_ff, window_in;
   logic [CNT_W-1:0]              n_ff, n_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                          new_ff, new_in;
   logic                          sub_ff, sub_in;
   logic [CNT_W-1:0]              k_ff, k_in;
   logic signed [SUM_W-1:0]       acc_ff, acc_in;
   logic                          rd_valid_ff, rd_valid_in;
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;

   logic signed [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];

   logic                    req_accept;
   logic                    ring_we;
   logic [PTR_W-1:0]        rd_addr;
   logic [CW-1:0]           cfg_wide, w_wide;
   logic [CNT_W-1:0]        w_eff;
   logic [CNT_W-1:0]        held0, held1, n_acc;
   logic                    sub_acc;
   logic [PTR_W-1:0]        wp_next;
   logic [AW-1:0]           sub_t, sub_w, sweep_t, sweep_w;
   logic signed [SUM_W-1:0] sample_ext, rd_ext, upd_sum;

   // Effective window: zero acts as one, anything above the ring size is clamped.
   always_comb begin
      cfg_wide = CW'(window_ff);
      if (cfg_wide == '0) begin
         w_wide = CW'(1);
      end else if (cfg_wide > CW'(MAX_WINDOW)) begin
         w_wide = CW'(MAX_WINDOW);
      end else begin
         w_wide = cfg_wide;
      end
      w_eff = w_wide[CNT_W-1:0];
   end

   // Counters for the beat on offer; the held count saturates at the ring size.
   always_comb begin
      held0   = req_new_series ? '0 : held_ff;
      held1   = (held0 < CNT_W'(MAX_WINDOW)) ? held0 + 1'b1 : held0;
      n_acc   = (held1 < w_eff) ? held1 : w_eff;
      sub_acc = (held0 >= w_eff);
      wp_next = (wp_ff == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_ff + 1'b1;
   end

   // Ring addresses: the sample leaving the window, and the re-sum walk.
   always_comb begin
      sub_t   = AW'(wp_ff) + AW'(MAX_WINDOW) - AW'(w_eff);
      sub_w   = (sub_t >= AW'(MAX_WINDOW)) ? sub_t - AW'(MAX_WINDOW) : sub_t;
      sweep_t = AW'(wp_ff) + AW'(MAX_WINDOW) - AW'(1) - AW'(k_ff);
      sweep_w = (sweep_t >= AW'(MAX_WINDOW)) ? sweep_t - AW'(MAX_WINDOW) : sweep_t;
   end

   // Sign extension of the held sample and of the ring read data.
   assign sample_ext = {{EXT_W{sample_ff[SAMPLE_BITS-1]}}, sample_ff};
   assign rd_ext     = {{EXT_W{rd_data_ff[SAMPLE_BITS-1]}}, rd_data_ff};
   assign upd_sum    = (new_ff ? '0 : sum_ff) + sample_ext - (sub_ff ? rd_ext : '0);

   assign req_stall  = (state_ff != FE_IDLE) || queue_full;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign push_count = n_ff;

   // Next state and outputs of the front sequencer.
   always_comb begin
      state_in    = state_ff;
      wp_in       = wp_ff;
      held_in     = held_ff;
      sum_in      = sum_ff;
      dirty_in    = dirty_ff;
      window_in   = window_ff;
      n_in        = n_ff;
      sample_in   = sample_ff;
      new_in      = new_ff;
      sub_in      = sub_ff;
      k_in        = k_ff;
      acc_in      = acc_ff;
      rd_valid_in = 1'b0;
      ring_we     = 1'b0;
      rd_addr     = sub_w[PTR_W-1:0];
      push_valid  = 1'b0;
      push_sum    = sum_ff;

      // A new window length invalidates the running sum.
      if (csr_valid) begin
         window_in = csr_window_length;
         dirty_in  = 1'b1;
      end

      case (state_ff)
         FE_IDLE: begin
            if (req_accept) begin
               ring_we   = 1'b1;
               wp_in     = wp_next;
               held_in   = held1;
               n_in      = n_acc;
               sample_in = req_sample;
               new_in    = req_new_series;
               sub_in    = sub_acc;
               k_in      = '0;
               acc_in    = '0;
               if (dirty_ff && !req_new_series) begin
                  state_in = FE_SWEEP;
               end else begin
                  state_in = FE_UPDATE;
               end
            end
         end
         FE_UPDATE: begin
            sum_in     = upd_sum;
            push_valid = 1'b1;
            push_sum   = upd_sum;
            if (new_ff) begin
               dirty_in = 1'b0;
            end
            state_in = FE_IDLE;
         end
         FE_SWEEP: begin
            rd_addr     = sweep_w[PTR_W-1:0];
            rd_valid_in = 1'b1;
            if (rd_valid_ff) begin
               acc_in = acc_ff + rd_ext;
            end
            k_in = k_ff + 1'b1;
            if (k_ff == n_ff - 1'b1) begin
               state_in = FE_FINISH;
            end
         end
         FE_FINISH: begin
            sum_in     = acc_ff + rd_ext;
            push_valid = 1'b1;
            push_sum   = acc_ff + rd_ext;
            dirty_in   = 1'b0;
            state_in   = FE_IDLE;
         end
         default: begin
            state_in = FE_IDLE;
         end
      endcase
   end

   // Sample ring: one write and one registered read per cycle; the read
   // returns the old entry when both hit the same slot.
   always_ff @(posedge clock) begin
      rd_data_ff <= ring_mem[rd_addr];
      if (ring_we) begin
         ring_mem[wp_ff] <= req_sample;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= FE_IDLE;
         wp_ff       <= '0;
         held_ff     <= '0;
         sum_ff      <= '0;
         dirty_ff    <= 1'b0;
         window_ff   <= WINDOW_RESET;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         wp_ff       <= wp_in;
         held_ff     <= held_in;
         sum_ff      <= sum_in;
         dirty_ff    <= dirty_in;
         window_ff   <= window_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   // Per-beat working registers.
   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      sample_ff <= sample_in;
      new_ff    <= new_in;
      sub_ff    <= sub_in;
      k_ff      <= k_in;
      acc_ff    <= acc_in;
   end

endmodule

/* rtl/cma_queue.sv */
// Short queue of (window sum, divisor) pairs between front and back parts.
// Depends on cma_pkg for its depth.
module cma_queue
   import cma_pkg::*;
#(
   parameter int SUM_W = 22,
   parameter int CNT_W = 7
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  logic signed [SUM_W-1:0] push_sum,
   input  logic [CNT_W-1:0]        push_count,
   output logic                    full,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output logic signed [SUM_W-1:0] pop_sum,
   output logic [CNT_W-1:0]        pop_count
);

   logic signed [SUM_W-1:0] sum_mem   [QUEUE_DEPTH];
   logic [CNT_W-1:0]        count_mem [QUEUE_DEPTH];

   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] fill_ff, fill_in;
   logic                   do_pop;

   assign full      = (fill_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign do_pop    = pop_valid && pop_ready;
   assign pop_sum   = sum_mem[rd_ptr_ff];
   assign pop_count = count_mem[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_valid && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !push_valid) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         sum_mem[wr_ptr_ff]   <= push_sum;
         count_mem[wr_ptr_ff] <= push_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

/* rtl/cma_divider.sv */
// Back part of the moving-average filter: bit-serial signed division of the
// window sum by the sample count, with an output register.
// Depends on cma_pkg.
module cma_divider
   import cma_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int SUM_W       = 22,
   parameter int CNT_W       = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [SUM_W-1:0]       in_sum,
   input  logic [CNT_W-1:0]              in_count,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_average
);

   localparam int STEP_W = $clog2(SUM_W + 1);

   dv_state_type state_ff, state_in;
   logic [SUM_W-1:0]              mag_ff, mag_in;
   logic [CNT_W-1:0]              rem_ff, rem_in;
   logic [CNT_W-1:0]              div_ff, div_in;
   logic                          neg_ff, neg_in;
   logic [STEP_W-1:0]             step_ff, step_in;
   logic                          out_valid_ff, out_valid_in;
   logic signed [SAMPLE_BITS-1:0] out_data_ff, out_data_in;

   logic [CNT_W:0]     rem_shift, rem_diff;
   logic               q_bit;
   logic [SUM_W-1:0]   quot;

   // One restoring step: shift in the next dividend bit and try to subtract.
   always_comb begin
      rem_shift = {rem_ff, mag_ff[SUM_W-1]};
      rem_diff  = rem_shift - {1'b0, div_ff};
      q_bit     = (rem_shift >= {1'b0, div_ff});
      quot      = neg_ff ? (~mag_ff + 1'b1) : mag_ff;
   end

   assign in_ready    = (state_ff == DV_IDLE);
   assign rsp_valid   = out_valid_ff;
   assign rsp_average = out_data_ff;

   // Next state and outputs of the divider sequencer.
   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;

      // The output beat leaves when the receiver takes it.
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         DV_IDLE: begin
            if (in_valid) begin
               neg_in   = in_sum[SUM_W-1];
               mag_in   = in_sum[SUM_W-1] ? (~in_sum + 1'b1) : in_sum;
               rem_in   = '0;
               div_in   = in_count;
               step_in  = '0;
               state_in = DV_RUN;
            end
         end
         DV_RUN: begin
            rem_in  = q_bit ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
            mag_in  = {mag_ff[SUM_W-2:0], q_bit};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               state_in = DV_DONE;
            end
         end
         DV_DONE: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_valid_in = 1'b1;
               out_data_in  = quot[SAMPLE_BITS-1:0];
               state_in     = DV_IDLE;
            end
         end
         default: begin
            state_in = DV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= DV_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      neg_ff      <= neg_in;
      step_ff     <= step_in;
      out_data_ff <= out_data_in;
   end

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the causal moving-average filter.
// Depends on cma_pkg and causal_moving_average; predicts every average
// from its own sample history and checks each result beat in order.
module testbench
   import cma_pkg::*;
();

   localparam int RING_DEPTH    = 64;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_BEATS   = 104;
   localparam int PHASE_COUNT   = 12;
   localparam int HOLDOFF_LEN   = 400;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               new_series;
   } sample_beat_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_sample = '0;
   logic               req_new_series = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_average;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CFG_W-1:0]   csr_window_length = WINDOW_RESET;

   // Stimulus and checking bookkeeping.
   sample_beat_type    pending_beats[$];
   logic signed [15:0] expected_averages[$];
   int                 beats_sent = 0;
   int                 averages_seen = 0;
   int                 mismatch_count = 0;
   logic               steady_phase = 1'b0;

   // Predictor state: sample history of the current series and the window.
   logic signed [15:0] sample_ring[RING_DEPTH];
   logic [5:0]         ring_head = '0;
   int                 series_held = 0;
   logic [CFG_W-1:0]   window_setting = WINDOW_RESET;

   // Hold-off bookkeeping for the receiver.
   int                 holdoff_left = 0;
   logic               holdoff_done = 1'b0;

   causal_moving_average DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .req_new_series    (req_new_series),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_average       (rsp_average),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_window_length (csr_window_length)
   );

   always #6 clock = ~clock;

   // Take one sample into the history and return the mean of the window.
   function automatic logic signed [15:0] predict_average(input logic signed [15:0] sample,
                                                         input logic new_series);
      int span;
      int total;
      int slot;
      span = int'(window_setting);
      if (span == 0) span = 1;
      if (span > RING_DEPTH) span = RING_DEPTH;
      if (new_series) series_held = 0;
      sample_ring[ring_head] = sample;
      ring_head = ring_head + 6'd1;
      if (series_held < RING_DEPTH) series_held++;
      if (series_held < span) span = series_held;
      total = 0;
      for (int j = 0; j < span; j++) begin
         slot = (int'(ring_head) + RING_DEPTH - 1 - j) % RING_DEPTH;
         total += int'(sample_ring[slot]);
      end
      // Integer division truncates toward zero, as the block does.
      return 16'(total / span);
   endfunction

   task automatic note_mismatch(input string what, input logic [15:0] wanted,
                                input logic [15:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch (%s) at %0t: expected average %0d, got %0d",
                  what, $realtime, $signed(wanted), $signed(got));
   endtask

   // Driver: offers queued sample beats and predicts each accepted one.
   always @(posedge clock) begin
      logic beat_taken;
      sample_beat_type beat;
      beat_taken = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_averages.push_back(predict_average(req_sample, req_new_series));
            beats_sent <= beats_sent + 1;
            beat_taken = 1'b1;
         end
         if (!req_valid || beat_taken) begin
            if (pending_beats.size() != 0 && (steady_phase || $urandom_range(99) >= 16)) begin
               beat = pending_beats.pop_front();
               req_valid      <= 1'b1;
               req_sample     <= beat.sample;
               req_new_series <= beat.new_series;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall: random idling, plus one long hold-off while beats are waiting.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holdoff_left != 0) begin
         rsp_stall    <= 1'b1;
         holdoff_left <= holdoff_left - 1;
      end else if (!holdoff_done && averages_seen >= 300 && pending_beats.size() > 20) begin
         rsp_stall    <= 1'b1;
         holdoff_left <= HOLDOFF_LEN;
         holdoff_done <= 1'b1;
      end else begin
         rsp_stall <= !steady_phase && ($urandom_range(99) < 16);
      end
   end

   // Monitor: compares each result beat with the oldest predicted average.
   always @(posedge clock) begin
      logic signed [15:0] wanted;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (averages_seen >= beats_sent) begin
            note_mismatch("unexpected beat", 16'hxxxx, rsp_average);
         end else begin
            wanted = expected_averages.pop_front();
            if (rsp_average !== wanted) note_mismatch("average", wanted, rsp_average);
         end
         averages_seen <= averages_seen + 1;
      end
   end

   task automatic add_beat(input logic signed [15:0] sample, input logic new_series);
      pending_beats.push_back('{sample: sample, new_series: new_series});
   endtask

   // Write the window register while the filter is idle.
   task automatic write_window(input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_valid         <= 1'b1;
      csr_window_length <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid      <= 1'b0;
      window_setting = value;
   endtask

   // Wait until every queued beat has been sent and every average returned.
   task automatic wait_until_drained;
      do @(negedge clock);
      while (pending_beats.size() != 0 || req_valid || averages_seen != beats_sent);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Random series: long runs with occasional restarts and varied sample styles.
   task automatic queue_random_phase(input int count);
      int style;
      logic restart;
      logic signed [15:0] sample;
      style = 0;
      for (int i = 0; i < count; i++) begin
         restart = (i == 0) ? ($urandom_range(1) == 1) : ($urandom_range(39) == 0);
         if (i == 0 || restart) style = $urandom_range(2);
         case (style)
            0: sample = 16'($urandom_range(65535));
            1: sample = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default: sample = 16'($urandom_range(16) - 8);
         endcase
         add_beat(sample, restart);
      end
   endtask

   // Stimulus sequence and final verdict.
   initial begin
      int phase_windows[PHASE_COUNT];
      phase_windows = '{1, 64, 0, 127, 65, 2, 63, 8, 0, 0, 0, 0};
      for (int p = 8; p < PHASE_COUNT; p++) phase_windows[p] = $urandom_range(127);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed series at the reset window: extremes, truncation and a full window.
      repeat (3) add_beat(16'sh7FFF, 1'b0);
      add_beat(16'sh8000, 1'b1);
      add_beat(16'sh8000, 1'b0);
      add_beat(-16'sd3, 1'b1);
      add_beat(16'sd0, 1'b0);
      add_beat(16'sd0, 1'b0);
      add_beat(16'sd3, 1'b1);
      add_beat(16'sd0, 1'b0);
      add_beat(16'sd1, 1'b1);
      add_beat(-16'sd1, 1'b0);
      add_beat(16'sh7FFF, 1'b0);
      add_beat(16'sh8000, 1'b0);
      add_beat(16'sd5, 1'b0);
      add_beat(-16'sd7, 1'b0);
      add_beat(16'sd100, 1'b0);
      add_beat(16'sh5555, 1'b0);
      add_beat(16'shAAAA, 1'b0);
      add_beat(-16'sd2, 1'b0);
      wait_until_drained();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_window(CFG_W'(phase_windows[p]));
         @(negedge clock);
         steady_phase = (p == 4);
         queue_random_phase(PHASE_BEATS);
         wait_until_drained();
      end
      steady_phase = 1'b0;

      if (expected_averages.size() != 0) begin
         mismatch_count++;
         $display("%0d predicted averages never arrived", expected_averages.size());
      end
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #(12 * 400000);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* files.f */
rtl/cma_pkg.sv
rtl/cma_front.sv
rtl/cma_queue.sv
rtl/cma_divider.sv
rtl/causal_moving_average.sv
tb/sv/testbench.sv
